// ===== src/elfd_pkg.sv =====
// Shared types and constants for the escaped length frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package elfd_pkg;

    // Reset values of the configuration registers
    localparam logic [7:0] START_BYTE_RST  = 8'h03;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'h1B;

    // Register index taken from paddr[2]
    typedef enum logic [0:0] {
        REG_START  = 1'b0,
        REG_ESCAPE = 1'b1
    } reg_index_t;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_ESC_LEN  = 3'd2,
        PH_COLLECT  = 3'd3,
        PH_ESC_DATA = 3'd4
    } phase_t;

    // Result kind
    typedef enum logic [0:0] {
        KIND_DATA  = 1'b0,
        KIND_ABORT = 1'b1
    } res_kind_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] escape_byte;
    } elfd_cfg_t;

    // One result transaction
    typedef struct packed {
        res_kind_t  kind;
        logic [7:0] data_byte;
        logic [7:0] position;
        logic [7:0] frame_length;
        logic       last;
    } elfd_result_t;

endpackage

`default_nettype wire

// ===== src/elfd_apb_regs.sv =====
// APB configuration registers: start byte and escape byte.
`timescale 1ns / 1ps
`default_nettype none

module elfd_apb_regs
    import elfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output elfd_cfg_t        cfg
);

    logic [7:0] start_byte_reg;
    logic [7:0] escape_byte_reg;
    logic       wr_en;
    reg_index_t reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = reg_index_t'(paddr[2]);

    // Update registers on the access phase of a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            escape_byte_reg <= ESCAPE_BYTE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_START:  start_byte_reg  <= pwdata[7:0];
                REG_ESCAPE: escape_byte_reg <= pwdata[7:0];
                default:    start_byte_reg  <= start_byte_reg;
            endcase
        end
    end

    // Return the selected register
    always_comb
    begin
        unique case (reg_sel)
            REG_START:  prdata = {24'd0, start_byte_reg};
            REG_ESCAPE: prdata = {24'd0, escape_byte_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.start_byte  = start_byte_reg;
    assign cfg.escape_byte = escape_byte_reg;

endmodule

`default_nettype wire

// ===== src/elfd_parser.sv =====
// Frame parser: phase, length and index state with one result per payload byte.
`timescale 1ns / 1ps
`default_nettype none

module elfd_parser
    import elfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire elfd_cfg_t   cfg,
    input  wire logic        accept,
    input  wire logic [7:0]  rx_byte,
    output logic             res_push,
    output elfd_result_t     res
);

    phase_t     phase_reg,  phase_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] index_reg,  index_next;

    logic       is_start;
    logic       is_escape;
    logic [7:0] esc_diff;
    logic [7:0] idx_inc;
    logic       done;

    assign is_start  = (rx_byte == cfg.start_byte);
    assign is_escape = (rx_byte == cfg.escape_byte);
    assign esc_diff  = rx_byte - cfg.escape_byte;
    assign idx_inc   = index_reg + 8'd1;
    assign done      = (idx_inc >= length_reg);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        index_next  = index_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    priority if (is_start)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else if (is_escape)
                    begin
                        phase_next = PH_ESC_LEN;
                    end
                    else
                    begin
                        length_next = rx_byte;
                        index_next  = 8'd0;
                        phase_next  = PH_COLLECT;
                    end
                end
                PH_ESC_LEN:
                begin
                    length_next = esc_diff;
                    index_next  = 8'd0;
                    phase_next  = PH_COLLECT;
                end
                PH_COLLECT:
                begin
                    priority if (is_start)
                    begin
                        phase_next = PH_LENGTH;
                    end
                    else if (is_escape)
                    begin
                        phase_next = PH_ESC_DATA;
                    end
                    else
                    begin
                        index_next = idx_inc;
                        phase_next = done ? PH_IDLE : PH_COLLECT;
                    end
                end
                PH_ESC_DATA:
                begin
                    index_next = idx_inc;
                    phase_next = done ? PH_IDLE : PH_COLLECT;
                end
                default:
                begin
                    phase_next = is_start ? PH_LENGTH : PH_IDLE;
                end
            endcase
        end
    end

    // Result for the accepted byte
    always_comb
    begin
        res_push         = 1'b0;
        res.kind         = KIND_DATA;
        res.data_byte    = rx_byte;
        res.position     = index_reg;
        res.frame_length = length_reg;
        res.last         = done;
        unique case (phase_reg)
            PH_COLLECT:
            begin
                priority if (is_start)
                begin
                    res_push      = accept;
                    res.kind      = KIND_ABORT;
                    res.data_byte = 8'd0;
                    res.last      = 1'b0;
                end
                else if (is_escape)
                begin
                    res_push = 1'b0;
                end
                else
                begin
                    res_push = accept;
                end
            end
            PH_ESC_DATA:
            begin
                res_push      = accept;
                res.data_byte = esc_diff;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            length_reg <= 8'd0;
            index_reg  <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            index_reg  <= index_next;
        end
    end

`ifndef SYNTHESIS
    // An abort sends the parser back to waiting for a length
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (res.kind == KIND_ABORT) |=> (phase_reg == PH_LENGTH))
        else $error("abort did not return to length phase");

    // The byte after a payload escape always yields a data transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == PH_ESC_DATA) |-> res_push && (res.kind == KIND_DATA))
        else $error("escaped payload byte lost");

    // A last byte ends the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.last |=> (phase_reg == PH_IDLE))
        else $error("frame not closed after last byte");
`endif

endmodule

`default_nettype wire

// ===== src/elfd_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the result consumer.
`timescale 1ns / 1ps
`default_nettype none

module elfd_out_buf
    import elfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire elfd_result_t push_data,
    output logic              space,
    output logic              res_valid,
    input  wire logic         res_ready,
    output elfd_result_t      res
);

    elfd_result_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg,  count_next;
    logic         pop;

    assign space     = (count_reg != 2'd2);
    assign res_valid = (count_reg != 2'd0);
    assign pop       = res_valid & res_ready;
    assign res       = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never exceeds two
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("result buffer overflow");

    // No push into a full buffer
    assert property (@(posedge clk) disable iff (!rst_n) push |-> space)
        else $error("push while full");

    // Pointers differ exactly when one entry is held
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("pointer and count mismatch");
`endif

endmodule

`default_nettype wire

// ===== src/escaped_length_frame_decoder.sv =====
// Top level of the escaped length frame decoder.
`timescale 1ns / 1ps
`default_nettype none

// Deframes a byte stream: waits for the start byte, reads a length byte
// (possibly escaped), then streams each payload byte out as one result
// transaction with its position, the frame length and a last flag; a start
// byte inside the payload gives an abort transaction. One received byte is
// taken per clock cycle while rx_ready is high, i.e. unless the two-entry
// output buffer is full. A byte is decoded in the cycle it is accepted and
// its result is registered in that buffer behind any results not yet taken.
// Start and escape bytes are set over APB at byte addresses 0x0 and 0x4;
// the user must set them only while the decoder is idle (not enforced).
module escaped_length_frame_decoder
    import elfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Received bytes
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    // Results
    output logic             res_valid,
    input  wire logic        res_ready,
    output logic             kind,
    output logic      [7:0]  data_byte,
    output logic      [7:0]  position,
    output logic      [7:0]  frame_length,
    output logic             last
);

    elfd_cfg_t    cfg;
    elfd_result_t parse_res;
    elfd_result_t buf_res;
    logic         parse_push;
    logic         buf_space;
    logic         accept;

    assign rx_ready = buf_space;
    assign accept   = rx_valid & rx_ready;

    elfd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    elfd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .res_push (parse_push),
        .res      (parse_res)
    );

    elfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (parse_push),
        .push_data (parse_res),
        .space     (buf_space),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (buf_res)
    );

    // Drive result fields
    assign kind         = buf_res.kind;
    assign data_byte    = buf_res.data_byte;
    assign position     = buf_res.position;
    assign frame_length = buf_res.frame_length;
    assign last         = buf_res.last;

endmodule

`default_nettype wire

// ===== tb/sv/escaped_length_frame_decoder_test.sv =====
// Self-checking testbench for the escaped length frame decoder.
`timescale 1ns / 1ps

module escaped_length_frame_decoder_test;
    import elfd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        res_valid;
    logic        res_ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic [7:0]  frame_length;
    logic        last;

    // Deframer state mirrored by the predictor
    elfd_cfg_t    model_cfg;
    phase_t       model_phase;
    logic [7:0]   model_length;
    logic [7:0]   model_index;
    elfd_result_t expected_results[$];

    int error_count;
    int bytes_sent;
    int frames_sent;
    int results_checked;
    int aborts_checked;
    int settings_used;
    bit rx_gaps_on;
    bit res_stalls_on;

    escaped_length_frame_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .position     (position),
        .frame_length (frame_length),
        .last         (last)
    );

    always #5 clk = ~clk;

    // Emit one decoded payload byte and advance the frame position
    function automatic elfd_result_t take_payload(input logic [7:0] value);
        elfd_result_t r;
        r.kind         = KIND_DATA;
        r.data_byte    = value;
        r.position     = model_index;
        r.frame_length = model_length;
        model_index    = model_index + 8'd1;
        r.last         = (model_index >= model_length);
        model_phase    = r.last ? PH_IDLE : PH_COLLECT;
        return r;
    endfunction

    // Decode one received byte; return 1 when it yields a result transaction
    function automatic bit decode_rx_byte(input logic [7:0] b, output elfd_result_t r);
        r = '0;
        case (model_phase)
            PH_LENGTH:
            begin
                if (b == model_cfg.start_byte)
                    return 1'b0;
                if (b == model_cfg.escape_byte)
                begin
                    model_phase = PH_ESC_LEN;
                    return 1'b0;
                end
                model_length = b;
                model_index  = 8'd0;
                model_phase  = PH_COLLECT;
                return 1'b0;
            end
            PH_ESC_LEN:
            begin
                model_length = 8'(b - model_cfg.escape_byte);
                model_index  = 8'd0;
                model_phase  = PH_COLLECT;
                return 1'b0;
            end
            PH_COLLECT:
            begin
                if (b == model_cfg.start_byte)
                begin
                    model_phase    = PH_LENGTH;
                    r.kind         = KIND_ABORT;
                    r.position     = model_index;
                    r.frame_length = model_length;
                    return 1'b1;
                end
                if (b == model_cfg.escape_byte)
                begin
                    model_phase = PH_ESC_DATA;
                    return 1'b0;
                end
                r = take_payload(b);
                return 1'b1;
            end
            PH_ESC_DATA:
            begin
                r = take_payload(8'(b - model_cfg.escape_byte));
                return 1'b1;
            end
            default:
            begin
                model_phase = (b == model_cfg.start_byte) ? PH_LENGTH : PH_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Match one accepted result transaction against the oldest expectation
    task automatic check_result();
        elfd_result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result: expected none actual %0d/%0h/%0d/%0d/%0d",
                     $time, kind, data_byte, position, frame_length, last);
            error_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("kind", 8'(want.kind), 8'(kind));
        compare_field("data_byte", want.data_byte, data_byte);
        compare_field("position", want.position, position);
        compare_field("frame_length", want.frame_length, frame_length);
        compare_field("last", 8'(want.last), 8'(last));
        results_checked++;
        if (want.kind == KIND_ABORT)
            aborts_checked++;
    endtask

    // Send one received byte and record what it should produce
    task automatic send_byte(input logic [7:0] b);
        int gap;
        elfd_result_t r;
        gap = rx_gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        if (decode_rx_byte(b, r))
            expected_results.push_back(r);
        bytes_sent++;
    endtask

    // One APB transaction: writes update the predictor, reads are checked against it
    task automatic apb_access(input bit is_write, input reg_index_t idx, input logic [7:0] value);
        logic [7:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (is_write)
        begin
            if (idx == REG_START)
                model_cfg.start_byte = value;
            else
                model_cfg.escape_byte = value;
        end
        else
        begin
            want = (idx == REG_START) ? model_cfg.start_byte : model_cfg.escape_byte;
            if (prdata !== {24'h0, want})
            begin
                $display("%0t: register %0d readback: expected %0h actual %0h",
                         $time, idx, {24'h0, want}, prdata);
                error_count++;
            end
        end
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold off until every expected result has drained, then let the pipe settle
    task automatic wait_idle();
        int guard;
        rx_valid <= 1'b0;
        guard = 0;
        while (expected_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] start_value, input logic [7:0] escape_value);
        wait_idle();
        apb_access(1'b1, REG_START, start_value);
        apb_access(1'b1, REG_ESCAPE, escape_value);
        apb_access(1'b0, REG_START, 8'h00);
        apb_access(1'b0, REG_ESCAPE, 8'h00);
        apb_release();
        settings_used++;
    endtask

    // Send v as data, escaped if it is a control byte or at random; if start == escape, a start v goes as v+1
    task automatic send_value(input logic [7:0] v);
        if (model_cfg.start_byte == model_cfg.escape_byte)
            send_byte((v == model_cfg.start_byte) ? 8'(v + 8'd1) : v);
        else if (v == model_cfg.start_byte || v == model_cfg.escape_byte ||
                 $urandom_range(0, 9) == 0)
        begin
            send_byte(model_cfg.escape_byte);
            send_byte(8'(v + model_cfg.escape_byte));
        end
        else
            send_byte(v);
    endtask

    // Well-formed frame with random content; now and then cut short so the next start aborts it
    task automatic send_frame();
        logic [7:0] len;
        logic [7:0] v;
        int count;
        int cut;
        if ($urandom_range(0, 39) == 0)
            len = 8'($urandom_range(0, 255));
        else
            len = 8'($urandom_range(0, 10));
        if (model_cfg.start_byte == model_cfg.escape_byte && len == model_cfg.start_byte)
            len = len + 8'd1;
        count = (len == 0) ? 1 : int'(len);
        cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : count;
        send_byte(model_cfg.start_byte);
        if ($urandom_range(0, 9) == 0)
            send_byte(model_cfg.start_byte);
        send_value(len);
        for (int i = 0; i < cut; i++)
        begin
            case ($urandom_range(0, 7))
                0: v = model_cfg.start_byte;
                1: v = model_cfg.escape_byte;
                default: v = 8'($urandom);
            endcase
            send_value(v);
        end
        frames_sent++;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    endtask

    // Drive the parser back to waiting for a start byte with filler bytes that are neither start nor escape
    task automatic finish_frame();
        logic [7:0] filler;
        filler = 8'd1;
        while (filler == model_cfg.start_byte || filler == model_cfg.escape_byte)
            filler = filler + 8'd1;
        while (model_phase != PH_IDLE)
            send_byte(filler);
    endtask

    task automatic test_register_access();
        apb_access(1'b0, REG_START, 8'h00);
        apb_access(1'b0, REG_ESCAPE, 8'h00);
        apb_release();
        set_config(8'hFF, 8'h00);
        set_config(START_BYTE_RST, ESCAPE_BYTE_RST);
    endtask

    // Junk before start, start as length, escaped length and data, zero length, aborts
    task automatic test_directed_frames();
        logic [7:0] seq [24];
        seq = '{8'h00, 8'hFF, ESCAPE_BYTE_RST,
                START_BYTE_RST, START_BYTE_RST, ESCAPE_BYTE_RST, 8'(ESCAPE_BYTE_RST + 8'd3),
                8'h00, ESCAPE_BYTE_RST, 8'(ESCAPE_BYTE_RST + START_BYTE_RST), 8'hFF,
                START_BYTE_RST, 8'h00, ESCAPE_BYTE_RST, ESCAPE_BYTE_RST,
                START_BYTE_RST, 8'h05, 8'hAA, START_BYTE_RST,
                8'h02, 8'h55, START_BYTE_RST, 8'h01, 8'h80};
        foreach (seq[i])
            send_byte(seq[i]);
        frames_sent += 5;
    endtask

    task automatic test_random_traffic(input logic [7:0] start_value,
                                       input logic [7:0] escape_value, input int count);
        int stop_at;
        set_config(start_value, escape_value);
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            rx_gaps_on    = ($urandom_range(0, 3) != 0);
            res_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_frame();
        end
        finish_frame();
    endtask

    // Result sink: stall at random, check every accepted transaction
    initial
    begin : result_sink
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = res_stalls_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            check_result();
        end
    end

    // Main sequence
    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rx_valid = 1'b0;
        rx_byte  = 8'h00;
        model_cfg.start_byte  = START_BYTE_RST;
        model_cfg.escape_byte = ESCAPE_BYTE_RST;
        model_phase   = PH_IDLE;
        model_length  = 8'd0;
        model_index   = 8'd0;
        error_count   = 0;
        bytes_sent    = 0;
        frames_sent   = 0;
        results_checked = 0;
        aborts_checked  = 0;
        settings_used   = 0;
        rx_gaps_on    = 1'b1;
        res_stalls_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_frames();
        test_random_traffic(START_BYTE_RST, ESCAPE_BYTE_RST, 340);
        test_random_traffic(8'h00, 8'hFF, 340);
        test_random_traffic(8'hFF, 8'h00, 340);
        test_random_traffic(8'h55, 8'h55, 300);
        test_random_traffic(8'($urandom), 8'($urandom), 340);

        wait_idle();
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
            error_count++;
        end
        $display("summary: %0d bytes sent in about %0d frames under %0d register settings",
                 bytes_sent, frames_sent, settings_used);
        $display("summary: %0d results checked, %0d aborts, %0d errors",
                 results_checked, aborts_checked, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/elfd_pkg.sv
src/elfd_apb_regs.sv
src/elfd_parser.sv
src/elfd_out_buf.sv
src/escaped_length_frame_decoder.sv
tb/sv/escaped_length_frame_decoder_test.sv
